// ===== design/pidsd_pkg.sv =====
// ----------------------------------------------------------------------------
// pidsd_pkg
// Shared types and constants of the PID regulator with smoothed derivative.
// ----------------------------------------------------------------------------
`default_nettype none

package pidsd_pkg;

  // Field widths.
  localparam int unsigned ErrW   = 32;  // Q16.16 error, integral, correction
  localparam int unsigned TickW  = 16;  // elapsed tick count
  localparam int unsigned GainW  = 24;  // unsigned Q8.16 gains
  localparam int unsigned LimW   = 31;  // integral limit
  localparam int unsigned SmthW  = 16;  // Q0.16 smoothing weight

  // Shared multiplier: a 33 bit operand times a 24 bit operand.
  localparam int unsigned MulAW  = 33;
  localparam int unsigned MulBW  = 24;
  localparam int unsigned ProdW  = MulAW + MulBW;

  // Divider: scaled derivative product over ticks plus one.
  localparam int unsigned DivDW  = ProdW - 16;
  localparam int unsigned DivSW  = TickW + 1;
  localparam int unsigned DivCntW = $clog2(DivDW + 1);

  // Clamp bound of the D term, 1.0 in Q16.16.
  localparam logic [DivSW-1:0] DLimit = DivSW'(65536);

  // APB side.
  localparam int unsigned ApbAW  = 5;
  localparam int unsigned ApbDW  = 32;

  typedef enum logic [2:0] {
    REG_GAIN_PROP,
    REG_GAIN_INTEG,
    REG_GAIN_DERIV,
    REG_INT_LIMIT,
    REG_SMOOTH_W
  } pidsd_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_M0,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_M4,
    ST_M5,
    ST_M6,
    ST_DIV,
    ST_DTERM,
    ST_SUM
  } pidsd_state_e;

endpackage

`default_nettype wire

// ===== design/pid_with_smoothed_derivative_top.sv =====
// ----------------------------------------------------------------------------
// pid_with_smoothed_derivative_top
// Q16.16 PID regulator with integral clamp and a smoothed previous error.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake               Contents
//  s_axis    in         tvalid/tready           op in tuser; error, ticks, preset
//  m_axis    out        tvalid/tready           saturated correction
//  apb       in         psel/penable/pready     five control registers
//
// A step request passes from acceptance to a result in the output register
// through states M0 to M5, which issue products on the shared 33x24
// multiplier, the one-bit-per-cycle divider, which divides the derivative
// product by ticks plus one, and DTERM and SUM, which clamp, sum and saturate.
// A clear request completes in the cycle it is accepted and gives no result.
// The input is ready only in the idle state; a finished result may wait in
// the output register while the next request is accepted, and a new result
// waits in the final state until the output register is free.
// Reset clears the registers to their defaults and zeroes both the integral
// and the previous error; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_with_smoothed_derivative_top (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // Request stream.
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  // [31:0] error_value, [47:32] elapsed_ticks, [79:48] preset_integral
  input  wire logic [79:0]                 s_axis_tdata,
  // [0] op (0 step, 1 clear)
  input  wire logic                        s_axis_tuser,
  // Result stream.
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // [31:0] correction
  output logic [31:0]                      m_axis_tdata,
  // Register port.
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [pidsd_pkg::ApbAW-1:0] paddr,
  input  wire logic [pidsd_pkg::ApbDW-1:0] pwdata,
  output logic [pidsd_pkg::ApbDW-1:0]      prdata,
  output logic                             pready
);
  import pidsd_pkg::*;

  // Clamps a wide signed value to plus or minus the integral limit.
  function automatic logic signed [ErrW-1:0] clamp_lim(
    input logic signed [ProdW:0] v,
    input logic [LimW-1:0]       lim
  );
    logic signed [ProdW:0] hi;
    logic signed [ProdW:0] lo;
    hi = $signed({{(ProdW+1-LimW){1'b0}}, lim});
    lo = -hi;
    if (v > hi) begin
      return hi[ErrW-1:0];
    end else if (v < lo) begin
      return lo[ErrW-1:0];
    end
    return v[ErrW-1:0];
  endfunction

  // Control registers.
  logic [GainW-1:0] gain_prop_q, gain_integ_q, gain_deriv_q;
  logic [LimW-1:0]  limit_q;
  logic [SmthW-1:0] smooth_q;

  // Sequencer and architectural state.
  pidsd_state_e state_q, state_d;
  logic signed [ErrW-1:0] integ_q, integ_d;
  logic signed [ErrW-1:0] prev_q, prev_d;
  logic                   out_valid_q, out_valid_d;
  logic [ErrW-1:0]        out_data_q, out_data_d;

  // Datapath registers.
  logic signed [ErrW-1:0] e_q, e_d;
  logic [TickW-1:0]       t_q, t_d;
  logic [ErrW-1:0]        emag_q, emag_d;
  logic                   eneg_q, eneg_d;
  logic [ProdW-1:0]       prod_q, prod_d;
  logic [TickW-1:0]       etlo_q, etlo_d;
  logic [ProdW-1:0]       inc_q, inc_d;
  logic signed [ErrW:0]   diff_q, diff_d;
  logic [ErrW:0]          dmag_q, dmag_d;
  logic                   dneg_q, dneg_d;
  logic signed [40:0]     p_q, p_d;
  logic signed [DivSW:0]  d_q, d_d;

  // Shared multiplier operands.
  logic [MulAW-1:0] mul_a;
  logic [MulBW-1:0] mul_b;

  // Divider.
  logic             div_start;
  logic             div_busy;
  logic [DivDW-1:0] div_quo;

  logic                    in_fire;
  logic                    cfg_wr;
  logic signed [ErrW-1:0]  in_err;
  logic signed [ErrW-1:0]  in_preset;
  logic signed [ProdW:0]   isum;
  logic signed [ErrW+1:0]  psum;
  logic [DivSW-1:0]        qclamp;
  logic signed [42:0]      total;

  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign in_err    = $signed(s_axis_tdata[31:0]);
  assign in_preset = $signed(s_axis_tdata[79:48]);
  assign cfg_wr    = psel && penable && pwrite && pready;

  assign s_axis_tready = state_q == ST_IDLE;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign pready        = 1'b1;

  // Register read-back; undecoded addresses read as zero.
  always_comb begin
    unique case (paddr[4:2])
      REG_GAIN_PROP:  prdata = ApbDW'(gain_prop_q);
      REG_GAIN_INTEG: prdata = ApbDW'(gain_integ_q);
      REG_GAIN_DERIV: prdata = ApbDW'(gain_deriv_q);
      REG_INT_LIMIT:  prdata = ApbDW'(limit_q);
      REG_SMOOTH_W:   prdata = ApbDW'(smooth_q);
      default:        prdata = '0;
    endcase
  end

  // Multiplier operand selection. Each product is registered in prod_q and
  // is consumed in the state after the one that issued it; M1 to M5 consume
  // the product of the previous state while they issue the next.
  always_comb begin
    unique case (state_q)
      ST_M0: begin  // |e| * ticks
        mul_a = MulAW'(emag_q);
        mul_b = MulBW'(t_q);
      end
      ST_M1: begin  // upper part of |e|*ticks times integral gain
        mul_a = MulAW'(prod_q[47:16]);
        mul_b = gain_integ_q;
      end
      ST_M2: begin  // lower 16 bits of |e|*ticks times integral gain
        mul_a = MulAW'(etlo_q);
        mul_b = gain_integ_q;
      end
      ST_M3: begin  // proportional product
        mul_a = MulAW'(emag_q);
        mul_b = gain_prop_q;
      end
      ST_M4: begin  // derivative product
        mul_a = dmag_q;
        mul_b = gain_deriv_q;
      end
      ST_M5: begin  // smoothing product
        mul_a = dmag_q;
        mul_b = MulBW'(smooth_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // Sequencer and datapath.
  always_comb begin
    state_d     = state_q;
    integ_d     = integ_q;
    prev_d      = prev_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    e_d         = e_q;
    t_d         = t_q;
    emag_d      = emag_q;
    eneg_d      = eneg_q;
    etlo_d      = etlo_q;
    inc_d       = inc_q;
    diff_d      = diff_q;
    dmag_d      = dmag_q;
    dneg_d      = dneg_q;
    p_d         = p_q;
    d_d         = d_q;
    div_start   = 1'b0;

    // The integral moves by the increment in the direction of the error.
    if (eneg_q) begin
      isum = $signed({{(ProdW+1-ErrW){integ_q[ErrW-1]}}, integ_q})
           - $signed({1'b0, inc_q});
    end else begin
      isum = $signed({{(ProdW+1-ErrW){integ_q[ErrW-1]}}, integ_q})
           + $signed({1'b0, inc_q});
    end

    // The smoothed error moves from e back toward the old value.
    if (dneg_q) begin
      psum = $signed({{2{e_q[ErrW-1]}}, e_q}) + $signed({1'b0, prod_q[48:16]});
    end else begin
      psum = $signed({{2{e_q[ErrW-1]}}, e_q}) - $signed({1'b0, prod_q[48:16]});
    end

    qclamp = (div_quo > DivDW'(DLimit)) ? DLimit : div_quo[DivSW-1:0];

    total = $signed({{2{p_q[40]}}, p_q})
          + $signed({{(43-ErrW){integ_q[ErrW-1]}}, integ_q})
          + $signed({{(42-DivSW){d_q[DivSW]}}, d_q});

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          e_d    = in_err;
          t_d    = s_axis_tdata[47:32];
          eneg_d = in_err[ErrW-1];
          emag_d = in_err[ErrW-1] ? ErrW'(-in_err) : ErrW'(in_err);
          if (s_axis_tuser) begin
            // Clear request: preset state, no result.
            integ_d = clamp_lim({{(ProdW+1-ErrW){in_preset[ErrW-1]}}, in_preset},
                                limit_q);
            prev_d  = in_err;
          end else begin
            state_d = ST_M0;
          end
        end
      end
      ST_M0: begin
        diff_d  = $signed({e_q[ErrW-1], e_q}) - $signed({prev_q[ErrW-1], prev_q});
        state_d = ST_M1;
      end
      ST_M1: begin
        etlo_d  = prod_q[15:0];
        dneg_d  = diff_q[ErrW];
        dmag_d  = diff_q[ErrW] ? (ErrW+1)'(-diff_q) : (ErrW+1)'(diff_q);
        state_d = ST_M2;
      end
      ST_M2: begin
        inc_d   = prod_q;
        state_d = ST_M3;
      end
      ST_M3: begin
        inc_d   = inc_q + ProdW'(prod_q[39:16]);
        state_d = ST_M4;
      end
      ST_M4: begin
        integ_d = clamp_lim(isum, limit_q);
        p_d     = eneg_q ? -$signed({1'b0, prod_q[55:16]})
                         :  $signed({1'b0, prod_q[55:16]});
        state_d = ST_M5;
      end
      ST_M5: begin
        // Dividing the product by 2^16 first and then by ticks plus one
        // gives the same truncated quotient as one division.
        div_start = 1'b1;
        state_d   = ST_M6;
      end
      ST_M6: begin
        prev_d  = psum[ErrW-1:0];
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (!div_busy) begin
          state_d = ST_DTERM;
        end
      end
      ST_DTERM: begin
        d_d     = dneg_q ? -$signed({1'b0, qclamp}) : $signed({1'b0, qclamp});
        state_d = ST_SUM;
      end
      ST_SUM: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          if (total > 43'sd2147483647) begin
            out_data_d = 32'h7FFF_FFFF;
          end else if (total < -43'sd2147483648) begin
            out_data_d = 32'h8000_0000;
          end else begin
            out_data_d = total[ErrW-1:0];
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      integ_q      <= '0;
      prev_q       <= '0;
      gain_prop_q  <= '0;
      gain_integ_q <= '0;
      gain_deriv_q <= '0;
      limit_q      <= '1;
      smooth_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      integ_q     <= integ_d;
      prev_q      <= prev_d;
      if (cfg_wr) begin
        unique case (paddr[4:2])
          REG_GAIN_PROP:  gain_prop_q  <= pwdata[GainW-1:0];
          REG_GAIN_INTEG: gain_integ_q <= pwdata[GainW-1:0];
          REG_GAIN_DERIV: gain_deriv_q <= pwdata[GainW-1:0];
          REG_INT_LIMIT:  limit_q      <= pwdata[LimW-1:0];
          REG_SMOOTH_W:   smooth_q     <= pwdata[SmthW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    e_q        <= e_d;
    t_q        <= t_d;
    emag_q     <= emag_d;
    eneg_q     <= eneg_d;
    prod_q     <= prod_d;
    etlo_q     <= etlo_d;
    inc_q      <= inc_d;
    diff_q     <= diff_d;
    dmag_q     <= dmag_d;
    dneg_q     <= dneg_d;
    p_q        <= p_d;
    d_q        <= d_d;
  end

  pidsd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q[ProdW-1:16]),
    .divisor_i  (DivSW'(t_q) + DivSW'(1)),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  // The integral never leaves the limit that was in force for the update.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_M4) |=>
      (integ_q <= $signed({2'b00, $past(limit_q)}) &&
       integ_q >= -$signed({2'b00, $past(limit_q)})))
    else $error("integral outside its limit after a step");

  // The derivative term reaching the final sum stays within plus or minus 1.0.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUM) |->
      (d_q <= $signed({1'b0, DLimit}) && d_q >= -$signed({1'b0, DLimit})))
    else $error("derivative term exceeds its clamp");

  // A result appears only when the sequencer leaves its final state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_SUM))
    else $error("result raised outside the final state");

  // No request is taken while the divider is still working.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !div_busy)
    else $error("input ready while the divider is busy");

endmodule

`default_nettype wire

// ===== design/pidsd_div.sv =====
// ----------------------------------------------------------------------------
// pidsd_div
// Restoring divider, one quotient bit per cycle, unsigned.
// ----------------------------------------------------------------------------
`default_nettype none

module pidsd_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [pidsd_pkg::DivDW-1:0]   dividend_i,
  input  wire logic [pidsd_pkg::DivSW-1:0]   divisor_i,
  output logic                               busy_o,
  output logic [pidsd_pkg::DivDW-1:0]        quotient_o
);
  import pidsd_pkg::*;

  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [DivSW-1:0]   rem_q, rem_d;
  logic [DivDW-1:0]   quo_q, quo_d;
  logic [DivSW-1:0]   div_q, div_d;
  logic [DivSW:0]     trial;
  logic [DivSW:0]     diff;
  logic               fits;

  // The dividend shifts out of the top of quo_q while quotient bits
  // shift in at the bottom.
  always_comb begin
    trial  = {rem_q, quo_q[DivDW-1]};
    diff   = trial - {1'b0, div_q};
    fits   = trial >= {1'b0, div_q};
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    if (start_i) begin
      cnt_d = DivCntW'(DivDW);
      rem_d = '0;
      quo_d = dividend_i;
      div_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      rem_d = fits ? diff[DivSW-1:0] : trial[DivSW-1:0];
      quo_d = {quo_q[DivDW-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign busy_o     = cnt_q != '0;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// ===== tb/pid_with_smoothed_derivative_top_test.sv =====
// ----------------------------------------------------------------------------
// pid_with_smoothed_derivative_top_test
// Self-checking bench for the Q16.16 PID regulator with smoothed derivative.
// A queue of requests feeds a clocked stream driver. The driver updates a
// bit-exact predictor of the integral, the smoothed previous error and the
// correction at each accepted request. A clocked monitor compares every
// correction with the oldest predicted one. Register writes go through the
// APB port only while the block is drained. A directed opening covers the
// extremes; random phases with fresh register settings follow.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_with_smoothed_derivative_top_test;
  import pidsd_pkg::*;

  localparam logic        OpStep        = 1'b0;
  localparam logic        OpClear       = 1'b1;
  localparam int unsigned NumRegs       = 5;
  localparam int unsigned IdlePct       = 26;
  localparam int unsigned SettleCycles  = 60;
  localparam int unsigned RandPhases    = 8;
  localparam int unsigned ItemsPerPhase = 88;
  localparam int unsigned SteadyPhase   = 2;
  localparam longint      CorrMax       = 64'sh7FFFFFFF;
  localparam longint      CorrMin       = -64'sh80000000;
  localparam longint      DTermBound    = 65536;

  typedef struct {
    logic        op;
    logic [31:0] err;
    logic [15:0] ticks;
    logic [31:0] preset;
  } pid_req_t;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [79:0]      s_axis_tdata  = '0;
  logic             s_axis_tuser  = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [31:0]      m_axis_tdata;
  logic             psel          = 1'b0;
  logic             penable       = 1'b0;
  logic             pwrite        = 1'b0;
  logic [ApbAW-1:0] paddr         = '0;
  logic [ApbDW-1:0] pwdata        = '0;
  logic [ApbDW-1:0] prdata;
  logic             pready;

  pid_req_t    req_pending_q[$];
  logic [31:0] corr_due_q[$];
  int unsigned fail_cnt = 0;
  bit          steady   = 1'b0;

  // Predictor copy of the registers and of the regulator state.
  longint cfg_kp     = 0;
  longint cfg_ki     = 0;
  longint cfg_kd     = 0;
  longint cfg_limit  = 64'sh7FFFFFFF;
  longint cfg_weight = 0;
  longint acc_integral = 0;
  longint smooth_prev  = 0;

  pid_with_smoothed_derivative_top i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  always #5 clk_i = ~clk_i;

  function automatic longint mag64(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint with_sign(bit neg, longint m);
    return neg ? -m : m;
  endfunction

  function automatic longint clamp_sym(longint v, longint bound);
    if (v > bound) return bound;
    if (v < -bound) return -bound;
    return v;
  endfunction

  // Advances the regulator state by one request and queues the correction
  // that a step produces. Every product is exact in 64 bits.
  function automatic void pid_advance(pid_req_t r);
    longint e, t, et, inc, p_term, diff, d_mag, d_term, back, sum;
    e = longint'($signed(r.err));
    t = longint'(r.ticks);
    if (r.op == OpClear) begin
      acc_integral = clamp_sym(longint'($signed(r.preset)), cfg_limit);
      smooth_prev  = e;
      return;
    end
    // The error-tick product is split so the gain multiply stays in range.
    et  = mag64(e) * t;
    inc = (et >>> 16) * cfg_ki + (((et % 65536) * cfg_ki) >>> 16);
    acc_integral = clamp_sym(acc_integral + with_sign(e < 0, inc), cfg_limit);
    p_term = with_sign(e < 0, (mag64(e) * cfg_kp) >>> 16);
    diff   = e - smooth_prev;
    d_mag  = (mag64(diff) * cfg_kd) / ((t + 1) * 65536);
    d_term = clamp_sym(with_sign(diff < 0, d_mag), DTermBound);
    back   = smooth_prev - e;
    smooth_prev = e + with_sign(back < 0, (mag64(back) * cfg_weight) >>> 16);
    sum = p_term + acc_integral + d_term;
    if (sum > CorrMax) sum = CorrMax;
    if (sum < CorrMin) sum = CorrMin;
    corr_due_q.push_back(sum[31:0]);
  endfunction

  // Stream driver: holds a request until it is accepted, then may idle.
  always @(posedge clk_i) begin : drive_req
    bit holding;
    holding = s_axis_tvalid;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        pid_advance(req_pending_q.pop_front());
        holding = 1'b0;
      end
      if (!holding) begin
        if (req_pending_q.size() != 0 && (steady || $urandom_range(99) >= IdlePct)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {req_pending_q[0].preset, req_pending_q[0].ticks,
                            req_pending_q[0].err};
          s_axis_tuser  <= req_pending_q[0].op;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk_i) begin : watch_corr
    logic [31:0] want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (corr_due_q.size() == 0) begin
          $display("%0t: correction with none pending, expected none, got %h",
                   $time, m_axis_tdata);
          fail_cnt++;
        end else begin
          want = corr_due_q.pop_front();
          if (m_axis_tdata !== want) begin
            $display("%0t: correction mismatch, expected %h, got %h",
                     $time, want, m_axis_tdata);
            fail_cnt++;
          end
        end
      end
      m_axis_tready <= steady || ($urandom_range(99) >= IdlePct);
    end
  end

  task automatic apb_write(input int unsigned idx, input logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ApbAW'(idx * 4);
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_GAIN_PROP:  cfg_kp     = longint'(val[23:0]);
      REG_GAIN_INTEG: cfg_ki     = longint'(val[23:0]);
      REG_GAIN_DERIV: cfg_kd     = longint'(val[23:0]);
      REG_INT_LIMIT:  cfg_limit  = longint'(val[30:0]);
      REG_SMOOTH_W:   cfg_weight = longint'(val[15:0]);
      default: ;
    endcase
  endtask

  task automatic set_all(input logic [31:0] kp, input logic [31:0] ki,
                         input logic [31:0] kd, input logic [31:0] lim,
                         input logic [31:0] w);
    apb_write(REG_GAIN_PROP, kp);
    apb_write(REG_GAIN_INTEG, ki);
    apb_write(REG_GAIN_DERIV, kd);
    apb_write(REG_INT_LIMIT, lim);
    apb_write(REG_SMOOTH_W, w);
    @(negedge clk_i);
  endtask

  // Waits until every request is accepted and every correction has come,
  // then lets the block's latency pass so a late clear cannot be in flight.
  task automatic settle();
    do @(negedge clk_i);
    while (req_pending_q.size() != 0 || corr_due_q.size() != 0 || s_axis_tvalid);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  function automatic void push_req(logic op, logic [31:0] err, logic [15:0] ticks,
                                   logic [31:0] preset);
    pid_req_t r;
    r.op     = op;
    r.err    = err;
    r.ticks  = ticks;
    r.preset = preset;
    req_pending_q.push_back(r);
  endfunction

  function automatic logic [31:0] pick_q16();
    int unsigned k;
    k = $urandom_range(19);
    if (k == 0) return 32'h7FFFFFFF;
    if (k == 1) return 32'h80000000;
    if (k == 2) return 32'h0;
    if (k == 3) return 32'hFFFFFFFF;
    if (k < 11) return $urandom();
    return 32'($urandom_range(32'h80000)) - 32'h40000;
  endfunction

  function automatic logic [15:0] pick_ticks();
    int unsigned k;
    k = $urandom_range(19);
    if (k < 12) return 16'($urandom_range(8));
    if (k < 17) return 16'($urandom_range(16'hFFFF));
    if (k == 17) return 16'h0;
    return 16'hFFFF;
  endfunction

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(3))
      0:       return 32'h0;
      1:       return 32'h00FFFFFF;
      2:       return $urandom_range(32'h30000);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_limit();
    case ($urandom_range(4))
      0:       return 32'h0;
      1:       return 32'h1;
      2:       return 32'h7FFFFFFF;
      3:       return $urandom_range(32'h01000000);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_weight();
    case ($urandom_range(3))
      0:       return 32'h0;
      1:       return 32'h0000FFFF;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: zero gains and the widest integral limit.
    push_req(OpStep, 32'h7FFFFFFF, 16'hFFFF, 32'h0);
    push_req(OpStep, 32'h80000000, 16'h0000, 32'h0);
    push_req(OpClear, 32'h00020000, 16'h0000, 32'h7FFFFFFF);
    push_req(OpStep, 32'h00010000, 16'h0001, 32'h0);
    settle();

    // Unit gains, half smoothing. Writes past the last register are ignored.
    for (int unsigned k = NumRegs; k < 8; k++) apb_write(k, $urandom());
    set_all(32'h00010000, 32'h00010000, 32'h00010000, 32'h7FFFFFFF, 32'h00008000);
    push_req(OpStep, 32'h00010000, 16'h0001, 32'h0);
    push_req(OpStep, 32'h00010000, 16'h0000, 32'h0);   // zero ticks
    push_req(OpStep, 32'h7FFFFFFF, 16'hFFFF, 32'h0);   // saturates high
    push_req(OpStep, 32'h80000000, 16'hFFFF, 32'h0);   // saturates low
    push_req(OpClear, 32'h12345678, 16'hFFFF, 32'h7FFFFFFF);
    push_req(OpStep, 32'h00000000, 16'h0003, 32'h0);
    push_req(OpClear, 32'h80000000, 16'h0000, 32'h80000000);
    push_req(OpStep, 32'hFFFFFFFF, 16'h0002, 32'h0);
    push_req(OpStep, 32'hFFFF0000, 16'h0001, 32'h0);
    settle();

    // Full-scale gains with a zero integral limit and maximum smoothing.
    set_all(32'hFFFFFFFF, 32'h00FFFFFF, 32'h00FFFFFF, 32'h0, 32'h0000FFFF);
    push_req(OpStep, 32'h7FFFFFFF, 16'hFFFF, 32'h0);
    push_req(OpStep, 32'h80000000, 16'hFFFF, 32'h0);
    push_req(OpClear, 32'h40000000, 16'h0000, 32'h7FFFFFFF);
    push_req(OpStep, 32'h00000001, 16'h0000, 32'h0);
    push_req(OpStep, 32'h80000000, 16'h0001, 32'h0);
    settle();

    // Build a large integral, then lower the limit beneath it.
    set_all(32'h0, 32'h00010000, 32'h0, 32'h7FFFFFFF, 32'h0);
    push_req(OpStep, 32'h01000000, 16'd100, 32'h0);
    settle();
    apb_write(REG_INT_LIMIT, 32'h00010000);
    @(negedge clk_i);
    push_req(OpStep, 32'h00000000, 16'h0000, 32'h0);
    push_req(OpClear, 32'h00000000, 16'h0000, 32'h7FFFFFFF);
    push_req(OpStep, 32'h00000000, 16'h0000, 32'h0);
    settle();

    // Random phases, each under fresh register settings.
    for (int unsigned ph = 0; ph < RandPhases; ph++) begin
      steady = (ph == SteadyPhase);
      set_all(pick_gain(), pick_gain(), pick_gain(), pick_limit(), pick_weight());
      for (int unsigned n = 0; n < ItemsPerPhase; n++) begin
        push_req(($urandom_range(99) < 12) ? OpClear : OpStep, pick_q16(), pick_ticks(),
                 $urandom_range(1) ? $urandom() : pick_q16());
      end
      settle();
    end
    steady = 1'b0;

    if (fail_cnt == 0 && corr_due_q.size() == 0) begin
      $display("pid_with_smoothed_derivative_top_test: clean");
    end else begin
      $display("pid_with_smoothed_derivative_top_test: errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("pid_with_smoothed_derivative_top_test: errors");
    $finish;
  end

endmodule

`default_nettype wire
